// ----- src/tdb_pkg.sv -----
// -----------------------------------------------------------------------------
// tdb_pkg
// Shared types and constants of the task demand bound pipeline.
// -----------------------------------------------------------------------------
package tdb_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int SPAN_WIDTH = DATA_WIDTH + 1;
   localparam int DIV_STEPS = SPAN_WIDTH;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EXEC_TIME = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TASK_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REL_DEADLINE = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESP_TIME = 2'd3;

   localparam logic [DATA_WIDTH-1:0] EXEC_TIME_RESET = 32'd1;
   localparam logic [DATA_WIDTH-1:0] TASK_PERIOD_RESET = 32'd1;
   localparam logic [DATA_WIDTH-1:0] REL_DEADLINE_RESET = 32'd0;
   localparam logic [DATA_WIDTH-1:0] RESP_TIME_RESET = 32'd0;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] exec_time;
      logic [DATA_WIDTH-1:0] task_period;
      logic [DATA_WIDTH-1:0] deadline;
      logic [DATA_WIDTH-1:0] resp_time;
   } cfg_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;
      logic [SPAN_WIDTH-1:0] dq;
   } div_lane_type;

   typedef struct packed {
      logic         ge;
      div_lane_type lane_a;
      div_lane_type lane_b;
   } stage_type;

endpackage

// ----- src/tdb_front.sv -----
// -----------------------------------------------------------------------------
// tdb_front
// Input stage: forms the offset past the deadline and the span with the
// response time, and loads both as dividends of the divider lanes.
// -----------------------------------------------------------------------------
module tdb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [31:0]              interval,
   input  tdb_pkg::cfg_type         cfg,
   output logic                     out_valid,
   output tdb_pkg::stage_type       out_data
);
   import tdb_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   stage_type       data_ff;
   stage_type       data_in;
   logic            ge;
   logic [DATA_WIDTH-1:0] offset;
   logic [SPAN_WIDTH-1:0] span;

   always_comb begin
      ge = (interval >= cfg.deadline);
      offset = ge ? (interval - cfg.deadline) : '0;
      span = {1'b0, interval} + {1'b0, cfg.resp_time};
      data_in.ge = ge;
      data_in.lane_a.rem = '0;
      data_in.lane_a.dq = {1'b0, offset};
      data_in.lane_b.rem = '0;
      data_in.lane_b.dq = span;
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ----- src/tdb_div_stage.sv -----
// -----------------------------------------------------------------------------
// tdb_div_stage
// One restoring division step for both divider lanes, with its registers.
// -----------------------------------------------------------------------------
module tdb_div_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [31:0]              divisor,
   input  logic                     in_valid,
   input  tdb_pkg::stage_type       in_data,
   output logic                     out_valid,
   output tdb_pkg::stage_type       out_data
);
   import tdb_pkg::*;

   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input logic [DATA_WIDTH-1:0] dvs);
      div_lane_type          res;
      logic [SPAN_WIDTH-1:0] trial;
      logic [SPAN_WIDTH-1:0] diff;
      logic                  take;
      trial = {lane.rem, lane.dq[SPAN_WIDTH-1]};
      diff = trial - {1'b0, dvs};
      take = (trial >= {1'b0, dvs});
      res.rem = take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      res.dq = {lane.dq[SPAN_WIDTH-2:0], take};
      return res;
   endfunction

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   always_comb begin
      data_in.ge = in_data.ge;
      data_in.lane_a = div_step(in_data.lane_a, divisor);
      data_in.lane_b = div_step(in_data.lane_b, divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ----- src/tdb_back.sv -----
// -----------------------------------------------------------------------------
// tdb_back
// Multiplies the job count by the execution time, rounds the job count
// up, and holds the finished result in the output register.
// -----------------------------------------------------------------------------
module tdb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  tdb_pkg::stage_type       in_data,
   input  tdb_pkg::cfg_type         cfg,
   output logic                     out_valid,
   output logic [63:0]              demand,
   output logic [32:0]              max_jobs,
   output logic                     feasible,
   output logic                     period_zero
);
   import tdb_pkg::*;

   logic                  mul_valid_ff;
   logic                  mul_ge_ff;
   logic [PROD_WIDTH-1:0] prod_ff;
   logic [PROD_WIDTH-1:0] prod_in;
   logic [SPAN_WIDTH-1:0] jobs_ff;
   logic [SPAN_WIDTH-1:0] jobs_in;

   logic                  out_valid_ff;
   logic [PROD_WIDTH-1:0] demand_ff;
   logic [PROD_WIDTH-1:0] demand_in;
   logic [SPAN_WIDTH-1:0] max_jobs_ff;
   logic [SPAN_WIDTH-1:0] max_jobs_in;
   logic                  feasible_ff;
   logic                  feasible_in;
   logic                  period_zero_ff;
   logic                  period_zero_in;

   always_comb begin
      prod_in = in_data.lane_a.dq[DATA_WIDTH-1:0] * cfg.exec_time;
      jobs_in = in_data.lane_b.dq + {{(SPAN_WIDTH-1){1'b0}}, (in_data.lane_b.rem != '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         jobs_ff <= jobs_in;
         mul_ge_ff <= in_data.ge;
      end
   end

   always_comb begin
      period_zero_in = (cfg.task_period == '0);
      feasible_in = (cfg.deadline >= cfg.exec_time) && (cfg.task_period >= cfg.exec_time)
                    && (cfg.exec_time != '0);
      demand_in = (mul_ge_ff && !period_zero_in)
                  ? prod_ff + {{DATA_WIDTH{1'b0}}, cfg.exec_time} : '0;
      max_jobs_in = period_zero_in ? '0 : jobs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         demand_ff <= demand_in;
         max_jobs_ff <= max_jobs_in;
         feasible_ff <= feasible_in;
         period_zero_ff <= period_zero_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign demand = demand_ff;
   assign max_jobs = max_jobs_ff;
   assign feasible = feasible_ff;
   assign period_zero = period_zero_ff;

endmodule

// ----- src/task_demand_bound.sv -----
// -----------------------------------------------------------------------------
// task_demand_bound
// Demand bound and maximum job count of one sporadic task, pipelined.
// -----------------------------------------------------------------------------
// The csr_ channel writes the execution time, period, relative deadline and
// response time of the task; a transfer there takes effect at once; the
// user must make it only while no interval is in flight, as the block
// does not enforce this. Each transfer on the req_ channel carries one
// interval. Each interval yields exactly one transfer on the rsp_ channel,
// in order, with the demand bound, the job count and two flags. An
// interval passes one input stage, 33 radix-2 division steps for the two
// quotients and two stages for the product and the rounded counts. Unless the
// pipeline stalls, one interval enters and one result leaves per cycle.
// Reset clears all valid bits and loads the register defaults. When the
// receiver holds rsp_ready low with a result waiting, the whole pipeline
// holds and req_ready falls; no item is lost or repeated.
// -----------------------------------------------------------------------------
module task_demand_bound (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tdb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                       csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [31:0]                       req_interval,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [63:0]                       rsp_demand,
   output logic [32:0]                       rsp_max_jobs,
   output logic                              rsp_feasible,
   output logic                              rsp_period_zero
);
   import tdb_pkg::*;

   logic [DATA_WIDTH-1:0] exec_time_ff;
   logic [DATA_WIDTH-1:0] exec_time_in;
   logic [DATA_WIDTH-1:0] task_period_ff;
   logic [DATA_WIDTH-1:0] task_period_in;
   logic [DATA_WIDTH-1:0] rel_deadline_ff;
   logic [DATA_WIDTH-1:0] rel_deadline_in;
   logic [DATA_WIDTH-1:0] resp_time_ff;
   logic [DATA_WIDTH-1:0] resp_time_in;

   cfg_type   cfg;
   logic      advance;
   logic      stage_valid [0:DIV_STEPS];
   stage_type stage_data [0:DIV_STEPS];

   assign csr_ready = 1'b1;

   always_comb begin
      exec_time_in = exec_time_ff;
      task_period_in = task_period_ff;
      rel_deadline_in = rel_deadline_ff;
      resp_time_in = resp_time_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_EXEC_TIME: exec_time_in = csr_data;
            REG_TASK_PERIOD: task_period_in = csr_data;
            REG_REL_DEADLINE: rel_deadline_in = csr_data;
            REG_RESP_TIME: resp_time_in = csr_data;
            default: exec_time_in = exec_time_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_time_ff <= EXEC_TIME_RESET;
         task_period_ff <= TASK_PERIOD_RESET;
         rel_deadline_ff <= REL_DEADLINE_RESET;
         resp_time_ff <= RESP_TIME_RESET;
      end else begin
         exec_time_ff <= exec_time_in;
         task_period_ff <= task_period_in;
         rel_deadline_ff <= rel_deadline_in;
         resp_time_ff <= resp_time_in;
      end
   end

   // A zero deadline register means the deadline equals the period.
   always_comb begin
      cfg.exec_time = exec_time_ff;
      cfg.task_period = task_period_ff;
      cfg.deadline = (rel_deadline_ff == '0) ? task_period_ff : rel_deadline_ff;
      cfg.resp_time = resp_time_ff;
   end

   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   tdb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .interval  (req_interval),
      .cfg       (cfg),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      tdb_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .divisor   (task_period_ff),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   tdb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (stage_valid[DIV_STEPS]),
      .in_data     (stage_data[DIV_STEPS]),
      .cfg         (cfg),
      .out_valid   (rsp_valid),
      .demand      (rsp_demand),
      .max_jobs    (rsp_max_jobs),
      .feasible    (rsp_feasible),
      .period_zero (rsp_period_zero)
   );

endmodule
